// ----- rtl/pcvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvs_pkg
// Shared types and constants of the plane contact vertex scan block.
// ----------------------------------------------------------------------------
package pcvs_pkg;

   // field widths
   localparam int COORD_W   = 32;
   localparam int NORM_W    = 18;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = DIFF_W + NORM_W;
   localparam int DEPTH_W   = PROD_W + 1;
   localparam int CSR_IDX_W = 3;

   // reset value of the normal y component (1.0 in signed Q2.16)
   localparam logic signed [NORM_W-1:0] NORMAL_Y_RESET = 18'sd65536;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLANE_PX = 3'd0,
      CSR_PLANE_PY = 3'd1,
      CSR_PLANE_PZ = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5
   } csr_index_type;

   // plane description held by the register bank
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic signed [NORM_W-1:0]  nx;
      logic signed [NORM_W-1:0]  ny;
      logic signed [NORM_W-1:0]  nz;
   } plane_cfg_type;

   // one scored vertex leaving the depth pipeline
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic signed [DEPTH_W-1:0] depth;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } depth_item_type;

endpackage

// ----- rtl/pcvs_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvs_cfg
// Register bank for the plane point and plane normal.
// ----------------------------------------------------------------------------
module pcvs_cfg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [pcvs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pcvs_pkg::COORD_W-1:0]           csr_wdata,
   output pcvs_pkg::plane_cfg_type                cfg
);

   pcvs_pkg::plane_cfg_type cfg_ff;
   pcvs_pkg::plane_cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pcvs_pkg::CSR_PLANE_PX: cfg_in.px = csr_wdata;
            pcvs_pkg::CSR_PLANE_PY: cfg_in.py = csr_wdata;
            pcvs_pkg::CSR_PLANE_PZ: cfg_in.pz = csr_wdata;
            pcvs_pkg::CSR_NORMAL_X: cfg_in.nx = csr_wdata[pcvs_pkg::NORM_W-1:0];
            pcvs_pkg::CSR_NORMAL_Y: cfg_in.ny = csr_wdata[pcvs_pkg::NORM_W-1:0];
            pcvs_pkg::CSR_NORMAL_Z: cfg_in.nz = csr_wdata[pcvs_pkg::NORM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.px <= '0;
         cfg_ff.py <= '0;
         cfg_ff.pz <= '0;
         cfg_ff.nx <= '0;
         cfg_ff.ny <= pcvs_pkg::NORMAL_Y_RESET;
         cfg_ff.nz <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/pcvs_depth.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvs_depth
// Three-stage pipeline computing the signed distance of a vertex to the plane:
// differences, products, then the sum.
// ----------------------------------------------------------------------------
module pcvs_depth (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  in_x,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  in_y,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  in_z,
   input  logic                                 in_last,
   input  pcvs_pkg::plane_cfg_type              cfg,
   output pcvs_pkg::depth_item_type             item
);

   // stage a: differences to the plane point
   logic                                 a_valid_ff;
   logic                                 a_last_ff;
   logic signed [pcvs_pkg::DIFF_W-1:0]   a_dx_ff, a_dy_ff, a_dz_ff;
   logic signed [pcvs_pkg::DIFF_W-1:0]   a_dx_in, a_dy_in, a_dz_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  a_x_ff, a_y_ff, a_z_ff;

   // stage b: products with the normal
   logic                                 b_valid_ff;
   logic                                 b_last_ff;
   logic signed [pcvs_pkg::PROD_W-1:0]   b_px_ff, b_py_ff, b_pz_ff;
   logic signed [pcvs_pkg::PROD_W-1:0]   b_px_in, b_py_in, b_pz_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  b_x_ff, b_y_ff, b_z_ff;

   // stage c: signed distance
   logic                                 c_valid_ff;
   logic                                 c_last_ff;
   logic signed [pcvs_pkg::DEPTH_W-1:0]  c_depth_ff;
   logic signed [pcvs_pkg::DEPTH_W-1:0]  c_depth_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  c_x_ff, c_y_ff, c_z_ff;

   // subtract
   always_comb begin
      a_dx_in = pcvs_pkg::DIFF_W'(in_x) - pcvs_pkg::DIFF_W'(cfg.px);
      a_dy_in = pcvs_pkg::DIFF_W'(in_y) - pcvs_pkg::DIFF_W'(cfg.py);
      a_dz_in = pcvs_pkg::DIFF_W'(in_z) - pcvs_pkg::DIFF_W'(cfg.pz);
   end

   // multiply, one multiplier per axis
   always_comb begin
      b_px_in = pcvs_pkg::PROD_W'(a_dx_ff) * pcvs_pkg::PROD_W'(cfg.nx);
      b_py_in = pcvs_pkg::PROD_W'(a_dy_ff) * pcvs_pkg::PROD_W'(cfg.ny);
      b_pz_in = pcvs_pkg::PROD_W'(a_dz_ff) * pcvs_pkg::PROD_W'(cfg.nz);
   end

   // sum, exact in the depth width
   always_comb begin
      c_depth_in = pcvs_pkg::DEPTH_W'(b_px_ff) + pcvs_pkg::DEPTH_W'(b_py_ff)
                 + pcvs_pkg::DEPTH_W'(b_pz_ff);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff  <= in_last;
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_dz_ff    <= a_dz_in;
         a_x_ff     <= in_x;
         a_y_ff     <= in_y;
         a_z_ff     <= in_z;
         b_last_ff  <= a_last_ff;
         b_px_ff    <= b_px_in;
         b_py_ff    <= b_py_in;
         b_pz_ff    <= b_pz_in;
         b_x_ff     <= a_x_ff;
         b_y_ff     <= a_y_ff;
         b_z_ff     <= a_z_ff;
         c_last_ff  <= b_last_ff;
         c_depth_ff <= c_depth_in;
         c_x_ff     <= b_x_ff;
         c_y_ff     <= b_y_ff;
         c_z_ff     <= b_z_ff;
      end
   end

   always_comb begin
      item.valid = c_valid_ff;
      item.last  = c_last_ff;
      item.depth = c_depth_ff;
      item.x     = c_x_ff;
      item.y     = c_y_ff;
      item.z     = c_z_ff;
   end

endmodule

// ----- rtl/pcvs_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvs_track
// Keeps the shallowest vertex below the plane and issues the body result
// into the output register on the last vertex.
// ----------------------------------------------------------------------------
module pcvs_track (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcvs_pkg::depth_item_type             item,
   output logic                                 hold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_collided,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_x,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_y,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_z
);

   logic                                 found_ff, found_in;
   logic signed [pcvs_pkg::DEPTH_W-1:0]  best_depth_ff, best_depth_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  best_x_ff, best_x_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  best_y_ff, best_y_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  best_z_ff, best_z_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_collided_ff, rsp_collided_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  rsp_x_ff, rsp_x_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  rsp_y_ff, rsp_y_in;
   logic signed [pcvs_pkg::COORD_W-1:0]  rsp_z_ff, rsp_z_in;

   logic                                 take;
   logic                                 found_now;
   logic signed [pcvs_pkg::COORD_W-1:0]  sel_x, sel_y, sel_z;
   logic                                 step;

   // a last item cannot leave while the output register is full and stalled
   assign hold = item.valid && item.last && rsp_valid_ff && rsp_stall;
   assign step = item.valid && !hold;

   // running compare, first vertex wins a tie
   always_comb begin
      take      = item.depth[pcvs_pkg::DEPTH_W-1]
               && (!found_ff || (item.depth > best_depth_ff));
      found_now = found_ff || take;
      sel_x     = take ? item.x : best_x_ff;
      sel_y     = take ? item.y : best_y_ff;
      sel_z     = take ? item.z : best_z_ff;
   end

   // best-so-far state, cleared after the last vertex
   always_comb begin
      found_in      = found_ff;
      best_depth_in = best_depth_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_z_in     = best_z_ff;
      if (step) begin
         if (item.last) begin
            found_in      = 1'b0;
            best_depth_in = '0;
            best_x_in     = '0;
            best_y_in     = '0;
            best_z_in     = '0;
         end else if (take) begin
            found_in      = 1'b1;
            best_depth_in = item.depth;
            best_x_in     = item.x;
            best_y_in     = item.y;
            best_z_in     = item.z;
         end
      end
   end

   // output register load and drain
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_collided_in = rsp_collided_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_z_in        = rsp_z_ff;
      if (step && item.last) begin
         rsp_valid_in    = 1'b1;
         rsp_collided_in = found_now;
         rsp_x_in        = found_now ? sel_x : '0;
         rsp_y_in        = found_now ? sel_y : '0;
         rsp_z_in        = found_now ? sel_z : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         best_depth_ff <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_z_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         found_ff      <= found_in;
         best_depth_ff <= best_depth_in;
         best_x_ff     <= best_x_in;
         best_y_ff     <= best_y_in;
         best_z_ff     <= best_z_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_collided_ff <= rsp_collided_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_z_ff        <= rsp_z_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_collided  = rsp_collided_ff;
   assign rsp_contact_x = rsp_x_ff;
   assign rsp_contact_y = rsp_y_ff;
   assign rsp_contact_z = rsp_z_ff;

endmodule

// ----- rtl/plane_contact_vertex_scan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_contact_vertex_scan_core
// Streams the vertices of a body against a plane and reports the shallowest
// vertex below it on the last vertex of the body.
//
// channel  direction  handshake               payload
// req      in         req_valid / req_stall   vertex x, y, z, last_vertex
// rsp      out        rsp_valid / rsp_stall   collided, contact x, y, z
// csr      in         csr_we                  csr_index, csr_wdata
//
// One vertex is taken every cycle while req_stall is low; the last vertex of a
// body passes subtract, multiply, sum, then compare into the output register.
// Reset is synchronous and clears the pipeline valids, the best-vertex state
// and the output valid; the plane registers return to a y-up normal.
// req_stall rises only when a last vertex meets a full output register that
// is stalled; all stages then hold until the result is taken.
// ----------------------------------------------------------------------------
module plane_contact_vertex_scan_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic signed [pcvs_pkg::COORD_W-1:0]  req_vertex_z,
   input  logic                                 req_last_vertex,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_collided,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_x,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_y,
   output logic signed [pcvs_pkg::COORD_W-1:0]  rsp_contact_z,
   input  logic                                 csr_we,
   input  logic [pcvs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcvs_pkg::COORD_W-1:0]         csr_wdata
);

   pcvs_pkg::plane_cfg_type   cfg;
   pcvs_pkg::depth_item_type  item;
   logic                      hold;
   logic                      req_take;

   assign req_stall = hold;
   assign req_take  = req_valid && !hold;

   // plane registers
   pcvs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // signed distance pipeline
   pcvs_depth u_depth (
      .clock    (clock),
      .reset    (reset),
      .advance  (!hold),
      .in_valid (req_take),
      .in_x     (req_vertex_x),
      .in_y     (req_vertex_y),
      .in_z     (req_vertex_z),
      .in_last  (req_last_vertex),
      .cfg      (cfg),
      .item     (item)
   );

   // best vertex tracking and output register
   pcvs_track u_track (
      .clock         (clock),
      .reset         (reset),
      .item          (item),
      .hold          (hold),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_collided  (rsp_collided),
      .rsp_contact_x (rsp_contact_x),
      .rsp_contact_y (rsp_contact_y),
      .rsp_contact_z (rsp_contact_z)
   );

endmodule

// ----- test/plane_contact_vertex_scan_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_contact_vertex_scan_core_tb
// Streams bodies of vertices through the plane contact scan core. It covers
// directed corner cases first: on-plane vertices, depth ties, clearing between
// bodies, extreme coordinates and odd normals. Random bodies then run under
// many plane settings, with random idling on both channels and one long result
// hold-off. A local depth predictor queues the expected contact of each body,
// and every result taken from the core is checked against the oldest one.
// ----------------------------------------------------------------------------
module plane_contact_vertex_scan_core_tb;

   // register indexes that no register answers to
   localparam logic [pcvs_pkg::CSR_IDX_W-1:0] CSR_IDX_NONE_LO = 3'd6;
   localparam logic [pcvs_pkg::CSR_IDX_W-1:0] CSR_IDX_NONE_HI = 3'd7;

   typedef struct packed {
      logic                                collided;
      logic signed [pcvs_pkg::COORD_W-1:0] x;
      logic signed [pcvs_pkg::COORD_W-1:0] y;
      logic signed [pcvs_pkg::COORD_W-1:0] z;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [pcvs_pkg::COORD_W-1:0] req_vertex_x = '0;
   logic signed [pcvs_pkg::COORD_W-1:0] req_vertex_y = '0;
   logic signed [pcvs_pkg::COORD_W-1:0] req_vertex_z = '0;
   logic                                req_last_vertex = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_collided;
   logic signed [pcvs_pkg::COORD_W-1:0] rsp_contact_x;
   logic signed [pcvs_pkg::COORD_W-1:0] rsp_contact_y;
   logic signed [pcvs_pkg::COORD_W-1:0] rsp_contact_z;
   logic                                csr_we = 1'b0;
   logic [pcvs_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [pcvs_pkg::COORD_W-1:0]        csr_wdata = '0;

   // predictor copy of the plane and of the running best vertex
   pcvs_pkg::plane_cfg_type             plane_model;
   logic                                found_model;
   longint                              depth_model;
   logic signed [pcvs_pkg::COORD_W-1:0] keep_x, keep_y, keep_z;

   contact_type expected_contacts[$];

   int  mismatch_count = 0;
   int  vertex_count   = 0;
   int  contact_count  = 0;
   int  setting_count  = 0;
   int  hold_cycles    = 0;
   logic quiet         = 1'b0;

   plane_contact_vertex_scan_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_vertex_z    (req_vertex_z),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_collided    (rsp_collided),
      .rsp_contact_x   (rsp_contact_x),
      .rsp_contact_y   (rsp_contact_y),
      .rsp_contact_z   (rsp_contact_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout: %0d contacts still pending", expected_contacts.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void note_mismatch(input string msg);
      if (mismatch_count < 10) $display("%s", msg);
      mismatch_count++;
   endfunction

   // depth of one vertex against the plane, exact, then keep the shallowest below it
   function automatic void score_vertex(input logic signed [pcvs_pkg::COORD_W-1:0] vx, vy, vz,
                                        input logic last);
      longint      dx, dy, dz;
      longint      depth;
      contact_type hit;
      dx = longint'(vx) - longint'($signed(plane_model.px));
      dy = longint'(vy) - longint'($signed(plane_model.py));
      dz = longint'(vz) - longint'($signed(plane_model.pz));
      depth = dx * longint'($signed(plane_model.nx))
            + dy * longint'($signed(plane_model.ny))
            + dz * longint'($signed(plane_model.nz));
      if (depth < 0 && (!found_model || depth > depth_model)) begin
         found_model = 1'b1;
         depth_model = depth;
         keep_x = vx;
         keep_y = vy;
         keep_z = vz;
      end
      if (last) begin
         hit.collided = found_model;
         hit.x = found_model ? keep_x : '0;
         hit.y = found_model ? keep_y : '0;
         hit.z = found_model ? keep_z : '0;
         expected_contacts.push_back(hit);
         found_model = 1'b0;
         depth_model = 0;
         keep_x = '0;
         keep_y = '0;
         keep_z = '0;
      end
   endfunction

   // result checker
   always @(posedge clock) begin : contact_check
      contact_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         contact_count++;
         if (expected_contacts.size() == 0) begin
            note_mismatch($sformatf("unexpected contact c=%0d (%h,%h,%h)", rsp_collided,
                                    rsp_contact_x, rsp_contact_y, rsp_contact_z));
         end else begin
            want = expected_contacts.pop_front();
            if (rsp_collided !== want.collided || rsp_contact_x !== want.x ||
                rsp_contact_y !== want.y || rsp_contact_z !== want.z)
               note_mismatch($sformatf(
                  "contact mismatch: want c=%0d (%h,%h,%h) got c=%0d (%h,%h,%h)",
                  want.collided, want.x, want.y, want.z, rsp_collided,
                  rsp_contact_x, rsp_contact_y, rsp_contact_z));
         end
      end
   end

   // receiver stall: short random bursts, or one long hold-off on request
   initial begin : rsp_stall_gen
      int n;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            n = hold_cycles;
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            hold_cycles = 0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // offer one vertex until it is taken; called at a falling edge
   task automatic send_vertex(input logic signed [pcvs_pkg::COORD_W-1:0] vx, vy, vz,
                              input logic last);
      if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) @(negedge clock);
      req_valid       = 1'b1;
      req_vertex_x    = vx;
      req_vertex_y    = vy;
      req_vertex_z    = vz;
      req_last_vertex = last;
      do @(posedge clock); while (req_stall);
      score_vertex(vx, vy, vz, last);
      vertex_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [pcvs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pcvs_pkg::COORD_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         pcvs_pkg::CSR_PLANE_PX: plane_model.px = data;
         pcvs_pkg::CSR_PLANE_PY: plane_model.py = data;
         pcvs_pkg::CSR_PLANE_PZ: plane_model.pz = data;
         pcvs_pkg::CSR_NORMAL_X: plane_model.nx = data[pcvs_pkg::NORM_W-1:0];
         pcvs_pkg::CSR_NORMAL_Y: plane_model.ny = data[pcvs_pkg::NORM_W-1:0];
         pcvs_pkg::CSR_NORMAL_Z: plane_model.nz = data[pcvs_pkg::NORM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait for every pending contact, then let the pipeline empty
   task automatic settle();
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // normals get junk in the unused upper bits of the write data
   task automatic set_plane(input logic [pcvs_pkg::COORD_W-1:0] px, py, pz,
                            input logic [pcvs_pkg::NORM_W-1:0] nx, ny, nz);
      write_reg(pcvs_pkg::CSR_PLANE_PX, px);
      write_reg(pcvs_pkg::CSR_PLANE_PY, py);
      write_reg(pcvs_pkg::CSR_PLANE_PZ, pz);
      write_reg(pcvs_pkg::CSR_NORMAL_X, {14'($urandom), nx});
      write_reg(pcvs_pkg::CSR_NORMAL_Y, {14'($urandom), ny});
      write_reg(pcvs_pkg::CSR_NORMAL_Z, {14'($urandom), nz});
      setting_count++;
   endtask

   function automatic logic signed [pcvs_pkg::COORD_W-1:0] near(
      input logic signed [pcvs_pkg::COORD_W-1:0] base);
      int offset;
      offset = int'($urandom_range(0, 256)) - 128;
      return base + pcvs_pkg::COORD_W'(offset <<< $urandom_range(0, 16));
   endfunction

   function automatic logic [pcvs_pkg::NORM_W-1:0] pick_normal();
      case ($urandom_range(0, 5))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return '0;
         3: return pcvs_pkg::NORM_W'($urandom);
         default: return pcvs_pkg::NORM_W'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   task automatic random_plane();
      logic [pcvs_pkg::COORD_W-1:0] p[3];
      foreach (p[i]) p[i] = ($urandom_range(0, 3) == 0) ? $urandom : near('0);
      set_plane(p[0], p[1], p[2], pick_normal(), pick_normal(), pick_normal());
   endtask

   // mostly vertices near the plane, some wild, some repeats for depth ties
   task automatic send_random_body(input int len);
      logic signed [pcvs_pkg::COORD_W-1:0] vx, vy, vz;
      vx = near(plane_model.px);
      vy = near(plane_model.py);
      vz = near(plane_model.pz);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               vx = $urandom;
               vy = $urandom;
               vz = $urandom;
            end
            2: ;
            3: vx = near(plane_model.px);
            default: begin
               vx = near(plane_model.px);
               vy = near(plane_model.py);
               vz = near(plane_model.pz);
            end
         endcase
         send_vertex(vx, vy, vz, i == len - 1);
      end
   endtask

   // reset plane is y up through the origin; the shallowest vertex below wins
   task automatic test_basic_depth();
      send_vertex(32'sd65536, -32'sd327680, 32'sd0, 1'b0);
      send_vertex(32'sd131072, -32'sd196608, 32'sd7, 1'b0);
      send_vertex(32'sd5, 32'sd0, 32'sd5, 1'b0);
      send_vertex(32'sd9, 32'sd65536, 32'sd9, 1'b1);
   endtask

   // vertices exactly on the plane are not below it
   task automatic test_on_plane();
      send_vertex(-32'sd1, 32'sd0, 32'sd1, 1'b0);
      send_vertex(32'sd4096, 32'sd0, -32'sd4096, 1'b1);
   endtask

   // first vertex stays on a depth tie; the next body starts clean
   task automatic test_tie_and_clear();
      send_vertex(32'sd100, -32'sd7, 32'sd1, 1'b0);
      send_vertex(32'sd200, -32'sd7, 32'sd2, 1'b0);
      send_vertex(32'sd300, 32'sd3, 32'sd3, 1'b1);
      send_vertex(32'sd1, 32'sd1, 32'sd1, 1'b1);
   endtask

   // extreme plane point, out-of-range normals, writes to unused indexes
   task automatic test_extreme_plane();
      settle();
      set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 18'h20000, 18'h1FFFF, 18'h30000);
      write_reg(CSR_IDX_NONE_LO, 32'hFFFF_FFFF);
      write_reg(CSR_IDX_NONE_HI, 32'h0000_0000);
      send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
   endtask

   // results held off while one-vertex bodies keep coming, then a full drain
   task automatic test_backpressure();
      settle();
      random_plane();
      hold_cycles = 80;
      for (int i = 0; i < 30; i++)
         send_vertex(near(plane_model.px), near(plane_model.py), near(plane_model.pz), 1'b1);
      settle();
   endtask

   task automatic test_random_bodies();
      int start;
      for (int phase = 0; phase < 9; phase++) begin
         settle();
         case (phase)
            0: set_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
            1: set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         18'h20000, 18'h20000, 18'h20000);
            default: random_plane();
         endcase
         start = vertex_count;
         while (vertex_count - start < 110)
            send_random_body(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8));
      end
   endtask

   // final stretch with no idling on either side
   task automatic test_quiet_tail();
      int start;
      settle();
      random_plane();
      quiet = 1'b1;
      start = vertex_count;
      while (vertex_count - start < 100) send_random_body($urandom_range(1, 8));
   endtask

   initial begin
      plane_model    = '0;
      plane_model.ny = pcvs_pkg::NORMAL_Y_RESET;
      found_model    = 1'b0;
      depth_model    = 0;
      keep_x         = '0;
      keep_y         = '0;
      keep_z         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_depth();
      test_on_plane();
      test_tie_and_clear();
      test_extreme_plane();
      test_backpressure();
      test_random_bodies();
      test_quiet_tail();

      settle();
      repeat (20) @(posedge clock);
      if (expected_contacts.size() != 0)
         note_mismatch($sformatf("%0d contacts never arrived", expected_contacts.size()));
      $display("covered %0d vertices and %0d body contacts over %0d plane settings",
               vertex_count, contact_count, setting_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
